// File: hdl/cfa_pkg.sv
// shared constants, types and helpers for the cell heap allocator
package cfa_pkg;

	localparam int HEAP_BYTES        = 65536;
	localparam int HEADER_BYTES      = 32;
	localparam int CELL_HEADER_BYTES = 8;
	localparam int STORE_DEPTH       = HEAP_BYTES / 8;
	localparam int IDX_W             = $clog2(STORE_DEPTH);
	localparam int CELL_BASE         = (HEADER_BYTES + 7) / 8 * 8;
	localparam int DVD_W             = 24;
	localparam int DVS_W             = 32;

	typedef logic signed [17:0] cell_t;
	typedef logic [IDX_W-1:0]   idx_t;

	typedef enum logic [1:0] {
		REQ_FORMAT = 2'd0,
		REQ_ALLOC  = 2'd1,
		REQ_FREE   = 2'd2,
		REQ_STATS  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NOSPACE = 2'd2
	} status_t;

	typedef struct packed {
		logic start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// clamp to the 18-bit signed range of a stored size
	function automatic cell_t sat18(input logic signed [19:0] v);
		cell_t r;
		if (v > 20'sd131071) r = 18'sd131071;
		else if (v < -20'sd131072) r = -18'sd131072;
		else r = v[17:0];
		return r;
	endfunction

endpackage

// File: hdl/cfa_ram.sv
// cell store: one signed size per 8-byte granule, registered read
module cfa_ram
	import cfa_pkg::*;
(
	input  logic  clk,
	input  logic  we,
	input  idx_t  waddr,
	input  cell_t wdata,
	input  idx_t  raddr,
	output cell_t rdata
);

	cell_t mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/cfa_div.sv
// restoring divider, one quotient bit per cycle
module cfa_div
	import cfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] q_q;
	logic [DVS_W:0]   rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;

	assign trial = {rem_q[DVS_W-1:0], q_q[DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			q_q   <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				q_q   <= {q_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = q_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without work");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != CNT_W'(1) |=> busy_q) else $error("divider stopped early");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0 || done_q || $past(busy_q) || cnt_q == '0)
		else $error("divider count left over");

endmodule

// File: hdl/cell_heap_first_fit_allocator.sv
// Cell heap first-fit allocator: one request word in, one result word out. Requests are
// taken one at a time; the block walks the cell chain in an 8192-entry store, reading each
// cell visited and then evaluating it, for an allocate, free or statistics request. Statistics
// adds two divisions for the score. A finished result is held in the output register while
// the next request is taken. The store has no reset: format the heap before other requests.
module cell_heap_first_fit_allocator
	import cfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // req_size[16:0], req_offset[32:17], zero pad
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // alloc_offset[15:0], free_blocks[29:16],
	                              // total_free[46:30], largest_free[63:47], frag_level[70:64]
	output logic [1:0]  m_tuser,  // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_WALK_RD, S_WALK_EV, S_SPLIT, S_NEXT_RD, S_NEXT_EV,
		S_PREV_RD, S_PREV_EV, S_DIV1, S_DIV2, S_DONE
	} state_t;

	state_t      state_q;
	logic [16:0] heap_size_q;
	logic        formatted_q;
	req_t        type_q;
	logic [17:0] need_q;
	logic [15:0] roff_q;
	logic [18:0] ptr_q;
	logic [18:0] next_q;
	cell_t       cur_q;
	logic [16:0] nfree_q;
	logic [31:0] tot_q;
	logic [16:0] big_q;
	logic [DVD_W-1:0] score_q;
	status_t     status_q;
	logic [15:0] aoff_q;
	logic [6:0]  frag_q;
	logic        we_q;
	idx_t        waddr_q;
	cell_t       wdata_q;
	idx_t        raddr;
	cell_t       rdata;
	div_req_t    dreq;
	div_rsp_t    drsp;
	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic [16:0] limit;
	logic [1:0]  in_type;
	logic [16:0] in_size;
	logic [15:0] in_off;
	logic [17:0] in_need;
	logic [16:0] span;
	logic [17:0] mag;
	logic [18:0] split_at;
	logic [18:0] free_end;
	logic [24:0] ratio_gap;
	logic [24:0] fin;

	assign limit    = (heap_size_q > 17'd65536) ? 17'd65536 : heap_size_q;
	assign in_type  = s_tuser;
	assign in_size  = s_tdata[16:0];
	assign in_off   = s_tdata[32:17];
	assign in_need  = ({1'b0, in_size} + 18'd7) & ~18'd7;
	assign span     = (limit - 17'(CELL_BASE)) & ~17'd7;
	assign mag      = rdata[17] ? 18'(-rdata) : 18'(rdata);
	assign split_at = ptr_q + {1'b0, need_q};
	assign free_end = {3'b0, in_off} + {1'b0, in_need};
	assign ratio_gap = (drsp.quotient <= 24'd100) ? 25'(24'd100 - drsp.quotient) : 25'd0;
	assign fin      = {1'b0, score_q} + ratio_gap;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	always_comb begin
		case (state_q)
			S_NEXT_RD: raddr = next_q[15:3];
			default:   raddr = ptr_q[15:3];
		endcase
	end

	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = nfree_q * 24'd100;
		dreq.divisor  = {10'b0, tot_q[31:10]} + 32'd1;
		if (state_q == S_DIV1 && !drsp.busy && !drsp.done) dreq.start = 1'b1;
		if (state_q == S_DIV2) begin
			dreq.dividend = {7'b0, big_q} * 24'd100;
			dreq.divisor  = tot_q;
			if (!drsp.busy && !drsp.done) dreq.start = 1'b1;
		end
	end

	cfa_ram u_ram (
		.clk  (clk),
		.we   (we_q),
		.waddr(waddr_q),
		.wdata(wdata_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	cfa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q <= 17'd65536;
		end else if (cfg_valid && cfg_ready) begin
			heap_size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			formatted_q <= 1'b0;
			we_q        <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
		end else begin
			we_q <= 1'b0;
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						type_q   <= req_t'(in_type);
						need_q   <= in_need;
						roff_q   <= in_off;
						status_q <= ST_OK;
						aoff_q   <= '0;
						frag_q   <= '0;
						nfree_q  <= '0;
						tot_q    <= '0;
						big_q    <= '0;
						ptr_q    <= 19'(CELL_BASE);
						next_q   <= free_end;
						state_q  <= S_DONE;
						if (req_t'(in_type) == REQ_FORMAT) begin
							formatted_q <= 1'b1;
							if (limit > 17'(CELL_BASE) && span != '0) begin
								we_q    <= 1'b1;
								waddr_q <= idx_t'(CELL_BASE / 8);
								wdata_q <= cell_t'({1'b0, span});
							end
						end else if (!formatted_q) begin
							status_q <= ST_INVALID;
						end else if (req_t'(in_type) == REQ_ALLOC) begin
							if (in_size == '0) status_q <= ST_INVALID;
							else state_q <= S_WALK_RD;
						end else if (req_t'(in_type) == REQ_FREE) begin
							if (in_size == '0 || in_off[2:0] != 3'd0 ||
							    in_off < 16'(CELL_BASE) || free_end > {2'b0, limit}) begin
								status_q <= ST_INVALID;
							end else begin
								we_q    <= 1'b1;
								waddr_q <= in_off[15:3];
								wdata_q <= sat18({2'b0, in_need});
								cur_q   <= sat18({2'b0, in_need});
								state_q <= (free_end < {2'b0, limit}) ? S_NEXT_RD : S_PREV_RD;
							end
						end else begin
							state_q <= S_WALK_RD;
						end
					end
				end
				S_WALK_RD: begin
					if (ptr_q >= {2'b0, limit}) begin
						if (type_q == REQ_ALLOC) begin
							status_q <= ST_NOSPACE;
							state_q  <= S_DONE;
						end else begin
							state_q <= (tot_q == '0) ? S_DONE : S_DIV1;
						end
					end else begin
						state_q <= S_WALK_EV;
					end
				end
				S_WALK_EV: begin
					if (rdata == '0) begin
						if (type_q == REQ_ALLOC) begin
							status_q <= ST_NOSPACE;
							state_q  <= S_DONE;
						end else begin
							state_q <= (tot_q == '0) ? S_DONE : S_DIV1;
						end
					end else if (type_q == REQ_ALLOC) begin
						if (!rdata[17] && 18'(rdata) >= need_q) begin
							aoff_q <= ptr_q[15:0];
							we_q   <= 1'b1;
							if ({1'b0, 18'(rdata)} > {1'b0, need_q} + 19'(CELL_HEADER_BYTES)) begin
								// split: tail stays free, head written next cycle
								we_q    <= (split_at < 19'(HEAP_BYTES));
								waddr_q <= split_at[15:3];
								wdata_q <= sat18(20'(rdata) - {2'b0, need_q});
								state_q <= S_SPLIT;
							end else begin
								waddr_q <= ptr_q[15:3];
								wdata_q <= sat18(-20'(rdata));
								state_q <= S_DONE;
							end
						end else begin
							ptr_q   <= ptr_q + {1'b0, mag};
							state_q <= S_WALK_RD;
						end
					end else begin
						if (!rdata[17]) begin
							nfree_q <= nfree_q + 17'd1;
							tot_q   <= tot_q + {14'b0, 18'(rdata)};
							if (rdata[16:0] > big_q) big_q <= rdata[16:0];
						end
						ptr_q   <= ptr_q + {1'b0, mag};
						state_q <= S_WALK_RD;
					end
				end
				S_SPLIT: begin
					we_q    <= 1'b1;
					waddr_q <= ptr_q[15:3];
					wdata_q <= sat18(-{2'b0, need_q});
					state_q <= S_DONE;
				end
				S_NEXT_RD: state_q <= S_NEXT_EV;
				S_NEXT_EV: begin
					if (!rdata[17] && rdata != '0) begin
						we_q    <= 1'b1;
						waddr_q <= roff_q[15:3];
						wdata_q <= sat18(20'(cur_q) + 20'(rdata));
						cur_q   <= sat18(20'(cur_q) + 20'(rdata));
					end
					state_q <= S_PREV_RD;
				end
				S_PREV_RD: begin
					state_q <= (ptr_q >= {3'b0, roff_q}) ? S_DONE : S_PREV_EV;
				end
				S_PREV_EV: begin
					if (rdata == '0) begin
						state_q <= S_DONE;
					end else if (ptr_q + {1'b0, mag} == {3'b0, roff_q} && !rdata[17]) begin
						// merge with the free neighbour in front
						we_q    <= 1'b1;
						waddr_q <= ptr_q[15:3];
						wdata_q <= sat18(20'(rdata) + 20'(cur_q));
						state_q <= S_DONE;
					end else begin
						ptr_q   <= ptr_q + {1'b0, mag};
						state_q <= S_PREV_RD;
					end
				end
				S_DIV1: begin
					if (drsp.done) begin
						score_q <= drsp.quotient;
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (drsp.done) begin
						frag_q  <= (fin > 25'd100) ? 7'd100 : fin[6:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= status_q;
						m_tdata_q  <= {1'b0, frag_q, big_q,
							((tot_q > 32'd131071) ? 17'h1FFFF : tot_q[16:0]),
							((nfree_q > 17'h3FFF) ? 14'h3FFF : nfree_q[13:0]),
							aoff_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("second request taken while busy");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE)) else $error("result not from done");
	a_div_only_stats: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> type_q == REQ_STATS && tot_q != '0) else $error("divider misuse");
	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		we_q |-> formatted_q) else $error("store written before format");

endmodule
